[sv/lvst_pkg.sv]
// Shared constants and codes for the latest-value slot table.
package lvst_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int MAX_LEN_DEF    = 64;
    localparam int BODY_BITS_DEF  = 64;

    localparam int ID_W   = 8;
    localparam int LEN_W  = 8;
    localparam int DATA_W = 64;
    localparam int OCC_W  = 5;
    localparam int CNT_W  = 32;

    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_POP   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

endpackage

[sv/lvst_slot_mem.sv]
// Slot memory: payload length and body word per slot, one access per cycle.
module lvst_slot_mem #(
    parameter int SLOT_COUNT = lvst_pkg::SLOT_COUNT_DEF,
    parameter int BODY_BITS  = lvst_pkg::BODY_BITS_DEF,
    parameter int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic                      rd_en,
    input  logic [IDX_W-1:0]          addr,
    input  logic [lvst_pkg::LEN_W-1:0] wr_len,
    input  logic [BODY_BITS-1:0]      wr_body,
    output logic [lvst_pkg::LEN_W-1:0] rd_len,
    output logic [BODY_BITS-1:0]      rd_body
);

    logic [lvst_pkg::LEN_W-1:0] len_mem  [SLOT_COUNT];
    logic [BODY_BITS-1:0]       body_mem [SLOT_COUNT];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            len_mem[addr]  <= wr_len;
            body_mem[addr] <= wr_body;
        end
        if (rd_en) begin
            rd_len  <= len_mem[addr];
            rd_body <= body_mem[addr];
        end
    end

endmodule

[sv/latest_value_slot_table_core.sv]
// Latest-value slot table: per-sensor mailbox with lowest-slot-first pop.
// Each result passes through the pipeline register, then the output register.
// One request per cycle when not stalled; the single slot-memory port is the limit.
// Valid bits and counters update at acceptance, so a following request sees them.
// Reset (synchronous, aresetn low) clears valid bits, counters and handshake
// state; the slot memory needs no clearing pass.
module latest_value_slot_table_core #(
    parameter int SLOT_COUNT = lvst_pkg::SLOT_COUNT_DEF,
    parameter int MAX_LEN    = lvst_pkg::MAX_LEN_DEF,
    parameter int BODY_BITS  = lvst_pkg::BODY_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // sensor_id[7:0], pkt_len[15:8], packet_data[79:16]
    input  logic [1:0]   s_tuser,   // action[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata,   // out_sensor_id[7:0], out_pkt_len[15:8],
                                    // out_packet_data[79:16], occupied_slots[84:80],
                                    // received_total[116:85], overwritten_total[148:117],
                                    // zero[151:149]
    output logic [1:0]   m_tuser    // status[1:0]
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_OCC_W = $clog2(SLOT_COUNT + 1);
    localparam int ID_W   = lvst_pkg::ID_W;
    localparam int LEN_W  = lvst_pkg::LEN_W;
    localparam int CNT_W  = lvst_pkg::CNT_W;

    logic [1:0]          action;
    logic [ID_W-1:0]     sensor_id;
    logic [LEN_W-1:0]    pkt_len;
    logic [63:0]         packet_data;

    assign action      = s_tuser;
    assign sensor_id   = s_tdata[7:0];
    assign pkt_len     = s_tdata[15:8];
    assign packet_data = s_tdata[79:16];

    logic [SLOT_COUNT-1:0] valid_reg, valid_next;
    logic [CNT_OCC_W-1:0]  occ_reg, occ_next;
    logic [CNT_W-1:0]      rcv_reg, rcv_next;
    logic [CNT_W-1:0]      ovw_reg, ovw_next;

    logic                  p_vld_reg, p_vld_next;
    logic [1:0]            p_status_reg;
    logic                  p_pop_ok_reg;
    logic [ID_W-1:0]       p_id_reg;
    logic [CNT_OCC_W-1:0]  p_occ_reg;
    logic [CNT_W-1:0]      p_rcv_reg;
    logic [CNT_W-1:0]      p_ovw_reg;

    logic                  m_vld_reg, m_vld_next;
    logic [151:0]          m_data_reg;
    logic [1:0]            m_status_reg;

    logic                  advance;
    logic                  accept;
    logic [IDX_W-1:0]      first_idx;
    logic                  any_valid;
    logic [IDX_W-1:0]      push_idx;
    logic                  in_range;
    logic                  len_ok;
    logic                  mem_wr;
    logic                  mem_rd;
    logic [IDX_W-1:0]      mem_addr;
    logic [1:0]            status;
    logic                  pop_ok;
    logic [LEN_W-1:0]      rd_len;
    logic [BODY_BITS-1:0]  rd_body;
    logic [8:0]            occ_wide;
    logic [151:0]          result;

    assign advance  = !m_vld_reg || m_tready;
    assign s_tready = !p_vld_reg || advance;
    assign accept   = s_tvalid && s_tready;

    assign push_idx = sensor_id[IDX_W-1:0];
    assign in_range = {1'b0, sensor_id} < 9'(SLOT_COUNT);
    assign len_ok   = pkt_len <= LEN_W'(MAX_LEN);

    always_comb begin
        first_idx = '0;
        any_valid = 1'b0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (valid_reg[i]) begin
                first_idx = IDX_W'(i);
                any_valid = 1'b1;
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        rcv_next   = rcv_reg;
        ovw_next   = ovw_reg;
        mem_wr     = 1'b0;
        mem_rd     = 1'b0;
        mem_addr   = push_idx;
        status     = lvst_pkg::ST_OK;
        pop_ok     = 1'b0;
        if (accept) begin
            unique case (action)
                lvst_pkg::ACT_PUSH: begin
                    if (!in_range) begin
                        status = lvst_pkg::ST_RANGE;
                    end else if (!len_ok) begin
                        status = lvst_pkg::ST_TOO_LONG;
                    end else begin
                        mem_wr = 1'b1;
                        if (valid_reg[push_idx]) begin
                            ovw_next = ovw_reg + 1'b1;
                        end else begin
                            occ_next = occ_reg + 1'b1;
                        end
                        valid_next[push_idx] = 1'b1;
                        rcv_next = rcv_reg + 1'b1;
                    end
                end
                lvst_pkg::ACT_POP: begin
                    mem_addr = first_idx;
                    if (any_valid) begin
                        mem_rd = 1'b1;
                        pop_ok = 1'b1;
                        valid_next[first_idx] = 1'b0;
                        occ_next = occ_reg - 1'b1;
                    end else begin
                        status = lvst_pkg::ST_EMPTY;
                    end
                end
                lvst_pkg::ACT_CLEAR: begin
                    ovw_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    lvst_slot_mem #(
        .SLOT_COUNT (SLOT_COUNT),
        .BODY_BITS  (BODY_BITS),
        .IDX_W      (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr),
        .rd_en   (mem_rd),
        .addr    (mem_addr),
        .wr_len  (pkt_len),
        .wr_body (packet_data[BODY_BITS-1:0]),
        .rd_len  (rd_len),
        .rd_body (rd_body)
    );

    assign p_vld_next = accept ? 1'b1 : (advance ? 1'b0 : p_vld_reg);
    assign m_vld_next = advance ? p_vld_reg : m_vld_reg;

    assign occ_wide = 9'(p_occ_reg);

    always_comb begin
        result = '0;
        if (p_pop_ok_reg) begin
            result[7:0]   = p_id_reg;
            result[15:8]  = rd_len;
            result[79:16] = 64'(rd_body);
        end
        result[84:80]   = occ_wide[4:0];
        result[116:85]  = p_rcv_reg;
        result[148:117] = p_ovw_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            occ_reg   <= '0;
            rcv_reg   <= '0;
            ovw_reg   <= '0;
            p_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            rcv_reg   <= rcv_next;
            ovw_reg   <= ovw_next;
            p_vld_reg <= p_vld_next;
            m_vld_reg <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_status_reg <= status;
            p_pop_ok_reg <= pop_ok;
            p_id_reg     <= ID_W'(first_idx);
            p_occ_reg    <= occ_next;
            p_rcv_reg    <= rcv_next;
            p_ovw_reg    <= ovw_next;
        end
        if (advance && p_vld_reg) begin
            m_data_reg   <= result;
            m_status_reg <= p_status_reg;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

endmodule

[bench/testbench.sv]
// Self-checking stream testbench for the latest-value slot table core.
`timescale 1ns / 100ps

module testbench;

    localparam int SLOTS      = lvst_pkg::SLOT_COUNT_DEF;
    localparam int LEN_LIMIT  = lvst_pkg::MAX_LEN_DEF;
    localparam int BODY_W     = lvst_pkg::BODY_BITS_DEF;
    localparam int ID_W       = lvst_pkg::ID_W;
    localparam int LEN_W      = lvst_pkg::LEN_W;
    localparam int DATA_W     = lvst_pkg::DATA_W;
    localparam int OCC_W      = lvst_pkg::OCC_W;
    localparam int CNT_W      = lvst_pkg::CNT_W;
    localparam int RAND_ITEMS = 1850;
    localparam int IDLE_LIMIT = 400;
    localparam int MAX_STALL  = 12;
    localparam int PRINT_CAP  = 100;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam logic [DATA_W-1:0] ONES = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] BODY_MASK = ONES >> (DATA_W - BODY_W);

    typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

    typedef struct {
        logic [1:0]        status;
        logic [ID_W-1:0]   sensor;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] body;
        logic [OCC_W-1:0]  occ;
        logic [CNT_W-1:0]  recv;
        logic [CNT_W-1:0]  ovw;
        logic [2:0]        pad;
    } slot_result_t;

    typedef struct {
        logic [1:0]        action;
        logic [ID_W-1:0]   sensor;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] body;
        logic              known;
        slot_result_t      want;
    } slot_request_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [ID_W-1:0]   sensor;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] body;
        logic              known;
        logic [1:0]        status;
        logic [OCC_W-1:0]  occ;
        logic [CNT_W-1:0]  recv;
        logic [CNT_W-1:0]  ovw;
    } directed_row_t;

    // known rows carry their result; the slot model predicts the rest
    localparam directed_row_t DIRECTED [25] = '{
        '{lvst_pkg::ACT_POP,   8'd0,   8'd0,   64'd0, 1'b1,
          lvst_pkg::ST_EMPTY,    5'd0, 32'd0, 32'd0},
        '{lvst_pkg::ACT_PUSH,  8'd16,  8'd0,   64'd0, 1'b1,
          lvst_pkg::ST_RANGE,    5'd0, 32'd0, 32'd0},
        '{lvst_pkg::ACT_PUSH,  8'd255, 8'd255, ONES,  1'b1,
          lvst_pkg::ST_RANGE,    5'd0, 32'd0, 32'd0},
        '{lvst_pkg::ACT_PUSH,  8'd0,   8'd65,  ONES,  1'b1,
          lvst_pkg::ST_TOO_LONG, 5'd0, 32'd0, 32'd0},
        '{lvst_pkg::ACT_PUSH,  8'd0,   8'd255, 64'd0, 1'b1,
          lvst_pkg::ST_TOO_LONG, 5'd0, 32'd0, 32'd0},
        '{lvst_pkg::ACT_PUSH,  8'd0,   8'd64,  ONES,  1'b1,
          lvst_pkg::ST_OK,       5'd1, 32'd1, 32'd0},
        '{lvst_pkg::ACT_PUSH,  8'd15,  8'd0,   64'd0, 1'b1,
          lvst_pkg::ST_OK,       5'd2, 32'd2, 32'd0},
        '{lvst_pkg::ACT_PUSH,  8'd15,  8'd1,   64'h5555_5555_5555_5555, 1'b1,
          lvst_pkg::ST_OK,       5'd2, 32'd3, 32'd1},
        '{ACT_NONE,            8'd255, 8'd255, ONES,  1'b1,
          lvst_pkg::ST_OK,       5'd2, 32'd3, 32'd1},
        '{lvst_pkg::ACT_CLEAR, 8'd0,   8'd0,   64'd0, 1'b1,
          lvst_pkg::ST_OK,       5'd2, 32'd3, 32'd0},
        '{lvst_pkg::ACT_PUSH,  8'd7,   8'd32,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0,
          lvst_pkg::ST_OK,       5'd0, 32'd0, 32'd0},
        '{lvst_pkg::ACT_PUSH,  8'd0,   8'd0,   64'h0123_4567_89AB_CDEF, 1'b0,
          lvst_pkg::ST_OK,       5'd0, 32'd0, 32'd0},
        '{lvst_pkg::ACT_CLEAR, 8'd255, 8'd255, ONES,  1'b0,
          lvst_pkg::ST_OK,       5'd0, 32'd0, 32'd0},
        '{lvst_pkg::ACT_POP,   8'd0,   8'd0,   64'd0, 1'b0,
          lvst_pkg::ST_OK,       5'd0, 32'd0, 32'd0},
        '{lvst_pkg::ACT_POP,   8'd255, 8'd255, ONES,  1'b0,
          lvst_pkg::ST_OK,       5'd0, 32'd0, 32'd0},
        '{lvst_pkg::ACT_POP,   8'd0,   8'd0,   64'd0, 1'b0,
          lvst_pkg::ST_OK,       5'd0, 32'd0, 32'd0},
        '{lvst_pkg::ACT_POP,   8'd0,   8'd0,   64'd0, 1'b1,
          lvst_pkg::ST_EMPTY,    5'd0, 32'd5, 32'd0},
        '{lvst_pkg::ACT_PUSH,  8'd1,   8'd64,  ONES,  1'b0,
          lvst_pkg::ST_OK,       5'd0, 32'd0, 32'd0},
        '{lvst_pkg::ACT_PUSH,  8'd14,  8'd63,  64'd0, 1'b0,
          lvst_pkg::ST_OK,       5'd0, 32'd0, 32'd0},
        '{lvst_pkg::ACT_POP,   8'd0,   8'd0,   64'd0, 1'b0,
          lvst_pkg::ST_OK,       5'd0, 32'd0, 32'd0},
        '{lvst_pkg::ACT_POP,   8'd0,   8'd0,   64'd0, 1'b0,
          lvst_pkg::ST_OK,       5'd0, 32'd0, 32'd0},
        '{lvst_pkg::ACT_POP,   8'd0,   8'd0,   64'd0, 1'b1,
          lvst_pkg::ST_EMPTY,    5'd0, 32'd7, 32'd0},
        '{lvst_pkg::ACT_PUSH,  8'd128, 8'd10,  64'd0, 1'b1,
          lvst_pkg::ST_RANGE,    5'd0, 32'd7, 32'd0},
        '{lvst_pkg::ACT_PUSH,  8'd3,   8'd65,  64'd0, 1'b1,
          lvst_pkg::ST_TOO_LONG, 5'd0, 32'd7, 32'd0},
        '{lvst_pkg::ACT_PUSH,  8'd3,   8'd64,  64'h8000_0000_0000_0001, 1'b0,
          lvst_pkg::ST_OK,       5'd0, 32'd0, 32'd0}
    };

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [79:0]  s_tdata  = '0;
    logic [1:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [151:0] m_tdata;
    logic [1:0]   m_tuser;

    latest_value_slot_table_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    slot_request_t request_list[$];
    slot_result_t  pending_results[$];
    int            accepted_n  = 0;
    int            checked_n   = 0;
    int            mismatch_n  = 0;

    // slot table model state
    logic              slot_full [0:SLOTS-1];
    logic [LEN_W-1:0]  slot_len  [0:SLOTS-1];
    logic [DATA_W-1:0] slot_word [0:SLOTS-1];
    logic [31:0]       occ_count  = '0;
    logic [CNT_W-1:0]  recv_count = '0;
    logic [CNT_W-1:0]  ovw_count  = '0;

    initial begin
        for (int k = 0; k < SLOTS; k++) begin
            slot_full[k] = 1'b0;
            slot_len[k]  = '0;
            slot_word[k] = '0;
        end
    end

    function automatic slot_result_t apply_request(input slot_request_t rq);
        slot_result_t r;
        logic         found;
        r = '{default: '0};
        found = 1'b0;
        case (rq.action)
            lvst_pkg::ACT_PUSH: begin
                if (rq.sensor >= SLOTS) begin
                    r.status = lvst_pkg::ST_RANGE;
                end else if (rq.len > LEN_LIMIT) begin
                    r.status = lvst_pkg::ST_TOO_LONG;
                end else begin
                    if (slot_full[rq.sensor])
                        ovw_count = ovw_count + 1'b1;
                    else
                        occ_count = occ_count + 1'b1;
                    slot_len[rq.sensor]  = rq.len;
                    slot_word[rq.sensor] = rq.body & BODY_MASK;
                    slot_full[rq.sensor] = 1'b1;
                    recv_count = recv_count + 1'b1;
                    r.status = lvst_pkg::ST_OK;
                end
            end
            lvst_pkg::ACT_POP: begin
                r.status = lvst_pkg::ST_EMPTY;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!found && slot_full[i]) begin
                        found        = 1'b1;
                        r.sensor     = ID_W'(i);
                        r.len        = slot_len[i];
                        r.body       = slot_word[i];
                        slot_full[i] = 1'b0;
                        occ_count    = occ_count - 1'b1;
                        r.status     = lvst_pkg::ST_OK;
                    end
                end
            end
            lvst_pkg::ACT_CLEAR: ovw_count = '0;
            default: ;
        endcase
        r.occ  = occ_count[OCC_W-1:0];
        r.recv = recv_count;
        r.ovw  = ovw_count;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_n < PRINT_CAP)
            $display("mismatch at result %0d: %s got %h, expected %h",
                     checked_n, what, got, want);
        mismatch_n++;
    endtask

    // accepted results are checked first, then accepted requests are predicted
    always @(posedge aclk) begin : monitor
        slot_result_t seen, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                seen.status = m_tuser;
                seen.sensor = m_tdata[7:0];
                seen.len    = m_tdata[15:8];
                seen.body   = m_tdata[79:16];
                seen.occ    = m_tdata[84:80];
                seen.recv   = m_tdata[116:85];
                seen.ovw    = m_tdata[148:117];
                seen.pad    = m_tdata[151:149];
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata[63:0], 64'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (seen.status !== want.status)
                        report_mismatch("status", 64'(seen.status), 64'(want.status));
                    if (seen.sensor !== want.sensor)
                        report_mismatch("out_sensor_id", 64'(seen.sensor),
                                        64'(want.sensor));
                    if (seen.len !== want.len)
                        report_mismatch("out_pkt_len", 64'(seen.len), 64'(want.len));
                    if (seen.body !== want.body)
                        report_mismatch("out_packet_data", seen.body, want.body);
                    if (seen.occ !== want.occ)
                        report_mismatch("occupied_slots", 64'(seen.occ), 64'(want.occ));
                    if (seen.recv !== want.recv)
                        report_mismatch("received_total", 64'(seen.recv),
                                        64'(want.recv));
                    if (seen.ovw !== want.ovw)
                        report_mismatch("overwritten_total", 64'(seen.ovw),
                                        64'(want.ovw));
                    if (seen.pad !== 3'd0)
                        report_mismatch("tdata padding", 64'(seen.pad), 64'd0);
                end
                checked_n++;
            end
            if (s_tvalid && s_tready) begin
                want = apply_request(request_list[accepted_n]);
                if (request_list[accepted_n].known)
                    want = request_list[accepted_n].want;
                pending_results.push_back(want);
                accepted_n++;
            end
        end
    end

    // sender: bursts of requests with random gaps
    int tx_next  = 0;
    int tx_burst = 0;
    int tx_gap   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_tready)) begin
            if (tx_gap > 0) begin
                tx_gap = tx_gap - 1;
                s_tvalid <= 1'b0;
            end else if (tx_next < request_list.size()) begin
                s_tdata  <= {request_list[tx_next].body, request_list[tx_next].len,
                             request_list[tx_next].sensor};
                s_tuser  <= request_list[tx_next].action;
                s_tvalid <= 1'b1;
                tx_next = tx_next + 1;
                if (tx_burst > 0) begin
                    tx_burst = tx_burst - 1;
                end else begin
                    tx_burst = $urandom_range(24);
                    tx_gap   = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: free, random or rotating-pattern stalls, stall runs capped
    rx_mode_t   rx_mode  = RX_FREE;
    int         rx_left  = 0;
    int         rx_stall = 0;
    logic [7:0] rx_pat   = 8'h5A;

    always @(posedge aclk) begin : receiver
        logic rdy;
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(2));
            rx_pat  = 8'($urandom_range(255, 1));
            rx_left = $urandom_range(200, 20);
        end
        rx_left = rx_left - 1;
        case (rx_mode)
            RX_FREE:   rdy = 1'b1;
            RX_RANDOM: rdy = ($urandom_range(99) < 65);
            default: begin
                rdy    = rx_pat[0];
                rx_pat = {rx_pat[0], rx_pat[7:1]};
            end
        endcase
        if (rx_stall >= MAX_STALL)
            rdy = 1'b1;
        rx_stall = rdy ? 0 : rx_stall + 1;
        m_tready <= rdy;
    end

    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin : main
        slot_request_t rq;
        int            push_weight;
        int            pick;
        for (int k = 0; k < 25; k++) begin
            rq.action      = DIRECTED[k].action;
            rq.sensor      = DIRECTED[k].sensor;
            rq.len         = DIRECTED[k].len;
            rq.body        = DIRECTED[k].body;
            rq.known       = DIRECTED[k].known;
            rq.want        = '{default: '0};
            rq.want.status = DIRECTED[k].status;
            rq.want.occ    = DIRECTED[k].occ;
            rq.want.recv   = DIRECTED[k].recv;
            rq.want.ovw    = DIRECTED[k].ovw;
            request_list.push_back(rq);
        end
        push_weight = 50;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            // phases that fill the table, drain it, or hover in between
            if (n % 150 == 0)
                push_weight = ($urandom_range(2) == 0) ? 20 :
                              ($urandom_range(1) == 0) ? 50 : 85;
            rq.known  = 1'b0;
            rq.want   = '{default: '0};
            rq.sensor = ID_W'($urandom_range(255));
            rq.len    = LEN_W'($urandom_range(255));
            rq.body   = {$urandom, $urandom};
            pick = $urandom_range(99);
            if (pick < push_weight) begin
                rq.action = lvst_pkg::ACT_PUSH;
                if ($urandom_range(99) < 85)
                    rq.sensor = ID_W'($urandom_range(SLOTS - 1));
                if ($urandom_range(99) < 85)
                    rq.len = LEN_W'($urandom_range(LEN_LIMIT));
            end else begin
                pick = $urandom_range(99);
                rq.action = (pick < 75) ? lvst_pkg::ACT_POP :
                            (pick < 90) ? lvst_pkg::ACT_CLEAR : ACT_NONE;
            end
            request_list.push_back(rq);
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_n < request_list.size())
            @(negedge aclk);
        while (pending_results.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);

        if (mismatch_n == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
